[design/rmq_pkg.sv]
// rmq_pkg: widths, pipeline word types and the saturation helper
// for the rotation matrix to quaternion unit; no dependencies
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int EW    = 16;              // element width
  localparam int FB    = 14;              // fraction bits
  localparam int NW    = EW + 1;          // off-diagonal sum or difference
  localparam int AW    = EW + 3;          // signed root argument
  localparam int XW    = AW - 1 + FB;     // clamped argument scaled by 2^FB
  localparam int RW    = (XW + 1) / 2;    // root width
  localparam int XPW   = 2 * RW;          // radicand, padded to whole digit pairs
  localparam int RMW   = RW + 1;          // root remainder
  localparam int SW    = RW + 1;          // scale = 2 * root
  localparam int DXW   = NW + FB;         // scaled numerator magnitude
  localparam int CW    = NW + FB + SW + EW;
  localparam int STEPS = 4;               // iterations per pipeline stage
  localparam int RSTG  = (RW + STEPS - 1) / STEPS;
  localparam int QSTG  = (EW + STEPS - 1) / STEPS;
  localparam int LATENCY = RSTG + QSTG + 3;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef struct packed {
    logic [1:0]           br;
    logic [2:0][NW-1:0]   num;
  } side_t;

  typedef struct packed {
    logic           valid;
    logic [XPW-1:0] x;
    side_t          side;
  } fr_t;

  typedef struct packed {
    logic           valid;
    logic [RMW-1:0] rem;
    logic [RW-1:0]  root;
    logic [XPW-1:0] xr;
    side_t          side;
  } rt_t;

  typedef struct packed {
    logic          neg;
    logic          zero;
    logic          ovf;
    logic [SW-1:0] rem;
    logic [EW-1:0] lo;
    logic [EW-1:0] q;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       br;
    logic [RW-1:0]    root;
    lane_t [2:0]      lane;
  } dv_t;

  // signed saturation of a sign and magnitude; big means past any limit
  function automatic logic [EW-1:0] sat_mag(input logic neg, input logic big,
                                            input logic [EW-1:0] mag);
    logic [EW-1:0] res;
    if (neg) begin
      if (big || mag >= {1'b1, {(EW-1){1'b0}}}) res = {1'b1, {(EW-1){1'b0}}};
      else res = EW'(-mag);
    end else begin
      if (big || mag > {1'b0, {(EW-1){1'b1}}}) res = {1'b0, {(EW-1){1'b1}}};
      else res = mag;
    end
    return res;
  endfunction

endpackage

[design/rmq_front.sv]
// rmq_front: branch choice, root argument and the three numerators
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic signed [rmq_pkg::EW-1:0] in_r00,
  input  logic signed [rmq_pkg::EW-1:0] in_r01,
  input  logic signed [rmq_pkg::EW-1:0] in_r02,
  input  logic signed [rmq_pkg::EW-1:0] in_r10,
  input  logic signed [rmq_pkg::EW-1:0] in_r11,
  input  logic signed [rmq_pkg::EW-1:0] in_r12,
  input  logic signed [rmq_pkg::EW-1:0] in_r20,
  input  logic signed [rmq_pkg::EW-1:0] in_r21,
  input  logic signed [rmq_pkg::EW-1:0] in_r22,
  output rmq_pkg::fr_t                 fr_o
);
  import rmq_pkg::*;

  logic signed [AW-1:0] e00, e11, e22, t, one, a;
  logic signed [NW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  logic [1:0]           br;
  fr_t                  fr_nxt, fr_r;

  always_comb begin
    e00 = AW'(in_r00);
    e11 = AW'(in_r11);
    e22 = AW'(in_r22);
    one = {{(AW-1){1'b0}}, 1'b1} << FB;
    t   = e00 + e11 + e22;
    d21_12 = NW'(in_r21) - NW'(in_r12);
    d02_20 = NW'(in_r02) - NW'(in_r20);
    d10_01 = NW'(in_r10) - NW'(in_r01);
    s01_10 = NW'(in_r01) + NW'(in_r10);
    s02_20 = NW'(in_r02) + NW'(in_r20);
    s12_21 = NW'(in_r12) + NW'(in_r21);
    // ties fall through to the later branch
    if (t > 0) begin
      br = BR_TRACE;
      a  = t + one;
    end else if (e00 > e11 && e00 > e22) begin
      br = BR_X;
      a  = one + e00 - e11 - e22;
    end else if (e11 > e22) begin
      br = BR_Y;
      a  = one + e11 - e00 - e22;
    end else begin
      br = BR_Z;
      a  = one + e22 - e00 - e11;
    end
    fr_nxt.valid   = in_valid;
    fr_nxt.x       = a[AW-1] ? '0 : XPW'({a[AW-2:0], {FB{1'b0}}});
    fr_nxt.side.br = br;
    case (br)
      BR_TRACE: fr_nxt.side.num = {d10_01, d02_20, d21_12};
      BR_X:     fr_nxt.side.num = {s02_20, s01_10, d21_12};
      BR_Y:     fr_nxt.side.num = {s12_21, s01_10, d02_20};
      BR_Z:     fr_nxt.side.num = {s12_21, s02_20, d10_01};
      default:  fr_nxt.side.num = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r.valid <= 1'b0;
    end else begin
      fr_r <= fr_nxt;
    end
  end

  assign fr_o = fr_r;
endmodule

[design/rmq_root.sv]
// rmq_root: pipelined digit-by-digit square root, four root bits per stage
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_root (
  input  logic         clk,
  input  logic         rst_n,
  input  rmq_pkg::fr_t fr_i,
  output rmq_pkg::rt_t rt_o
);
  import rmq_pkg::*;

  rt_t init_c;
  rt_t st_r   [RSTG];
  rt_t st_nxt [RSTG];

  always_comb begin
    init_c.valid = fr_i.valid;
    init_c.rem   = '0;
    init_c.root  = '0;
    init_c.xr    = fr_i.x;
    init_c.side  = fr_i.side;
  end

  for (genvar s = 0; s < RSTG; s++) begin : g_stg
    rt_t src;
    if (s == 0) begin : g_first
      assign src = init_c;
    end else begin : g_next
      assign src = st_r[s-1];
    end

    always_comb begin
      logic [RMW+1:0] rem2;
      logic [RMW+1:0] trial;
      rt_t            cur;
      cur = src;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < RW) begin
          rem2  = {cur.rem, cur.xr[XPW-1 -: 2]};
          trial = (RMW+2)'({cur.root, 2'b01});
          if (rem2 >= trial) begin
            rem2     = rem2 - trial;
            cur.root = {cur.root[RW-2:0], 1'b1};
          end else begin
            cur.root = {cur.root[RW-2:0], 1'b0};
          end
          cur.rem = rem2[RMW-1:0];
          cur.xr  = cur.xr << 2;
        end
      end
      st_nxt[s] = cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[s].valid <= 1'b0;
      end else begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign rt_o = st_r[RSTG-1];
endmodule

[design/rmq_quot.sv]
// rmq_quot: three restoring dividers in lockstep, numerator * 2^FB / scale
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_quot (
  input  logic         clk,
  input  logic         rst_n,
  input  rmq_pkg::rt_t rt_i,
  output rmq_pkg::dv_t dv_o
);
  import rmq_pkg::*;

  dv_t setup_nxt, setup_r;
  dv_t st_r   [QSTG];
  dv_t st_nxt [QSTG];

  // sign/magnitude split and the out-of-range test against scale * 2^EW
  always_comb begin
    logic [SW-1:0]  s;
    logic [NW-1:0]  n;
    logic [NW-1:0]  mag;
    logic [DXW-1:0] xx;
    s = {rt_i.root, 1'b0};
    setup_nxt.valid = rt_i.valid;
    setup_nxt.br    = rt_i.side.br;
    setup_nxt.root  = rt_i.root;
    for (int l = 0; l < 3; l++) begin
      n   = rt_i.side.num[l];
      mag = n[NW-1] ? NW'(-n) : n;
      xx  = {mag, {FB{1'b0}}};
      setup_nxt.lane[l].neg  = n[NW-1];
      setup_nxt.lane[l].zero = (mag == '0);
      setup_nxt.lane[l].ovf  = CW'(xx) >= CW'({s, {EW{1'b0}}});
      setup_nxt.lane[l].rem  = SW'(xx >> EW);
      setup_nxt.lane[l].lo   = xx[EW-1:0];
      setup_nxt.lane[l].q    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r.valid <= 1'b0;
    end else begin
      setup_r <= setup_nxt;
    end
  end

  for (genvar g = 0; g < QSTG; g++) begin : g_stg
    dv_t src;
    if (g == 0) begin : g_first
      assign src = setup_r;
    end else begin : g_next
      assign src = st_r[g-1];
    end

    always_comb begin
      logic [SW:0]   rem2;
      logic [SW-1:0] s;
      dv_t           cur;
      cur = src;
      s   = {cur.root, 1'b0};
      for (int l = 0; l < 3; l++) begin
        for (int k = 0; k < STEPS; k++) begin
          if (g * STEPS + k < EW) begin
            rem2 = {cur.lane[l].rem, cur.lane[l].lo[EW-1]};
            if (rem2 >= {1'b0, s}) begin
              rem2 = rem2 - {1'b0, s};
              cur.lane[l].q = {cur.lane[l].q[EW-2:0], 1'b1};
            end else begin
              cur.lane[l].q = {cur.lane[l].q[EW-2:0], 1'b0};
            end
            cur.lane[l].rem = rem2[SW-1:0];
            cur.lane[l].lo  = cur.lane[l].lo << 1;
          end
        end
      end
      st_nxt[g] = cur;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[g].valid <= 1'b0;
      end else begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign dv_o = st_r[QSTG-1];
endmodule

[design/rmq_back.sv]
// rmq_back: saturation and placement of the four components, output register
// depends on rmq_pkg
`timescale 1ns / 1ps
module rmq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmq_pkg::dv_t          dv_i,
  output logic                  out_valid,
  output logic [rmq_pkg::EW-1:0] out_quat_w,
  output logic [rmq_pkg::EW-1:0] out_quat_x,
  output logic [rmq_pkg::EW-1:0] out_quat_y,
  output logic [rmq_pkg::EW-1:0] out_quat_z,
  output logic [1:0]            out_branch_taken
);
  import rmq_pkg::*;

  logic [RW+EW-1:0]     domw;
  logic [EW-1:0]        dom;
  logic [2:0][EW-1:0]   v;
  logic [3:0][EW-1:0]   q_nxt, q_r;
  logic                 valid_r;
  logic [1:0]           br_r;

  always_comb begin
    domw = (RW+EW)'(dv_i.root >> 1);
    dom  = sat_mag(1'b0, |domw[RW+EW-1:EW], domw[EW-1:0]);
    for (int l = 0; l < 3; l++) begin
      // zero scale lands in ovf, so only a zero numerator needs its own arm
      if (dv_i.lane[l].zero) v[l] = '0;
      else v[l] = sat_mag(dv_i.lane[l].neg, dv_i.lane[l].ovf, dv_i.lane[l].q);
    end
    case (dv_i.br)
      BR_TRACE: q_nxt = {v[2], v[1], v[0], dom};
      BR_X:     q_nxt = {v[2], v[1], dom, v[0]};
      BR_Y:     q_nxt = {v[2], dom, v[1], v[0]};
      BR_Z:     q_nxt = {dom, v[2], v[1], v[0]};
      default:  q_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    q_r  <= q_nxt;
    br_r <= dv_i.br;
  end

  assign out_valid        = valid_r;
  assign out_quat_w       = q_r[0];
  assign out_quat_x       = q_r[1];
  assign out_quat_y       = q_r[2];
  assign out_quat_z       = q_r[3];
  assign out_branch_taken = br_r;
endmodule

[design/rotation_matrix_to_quaternion_unit.sv]
// Rotation matrix to unit quaternion, four-branch trace method. A matrix word
// is taken on every cycle that start is high and busy is low (busy is high
// only while rst_n is low) and its quaternion appears with out_valid after
// passing through one input stage, four stages of the root pipeline (four
// root bits each), a setup stage and four stages of the three dividers (four
// quotient bits each), and the output register. The sink cannot stall;
// results must be taken in the cycle they are shown.
// depends on rmq_pkg, rmq_front, rmq_root, rmq_quot, rmq_back
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [rmq_pkg::EW-1:0] in_r00,
  input  logic signed [rmq_pkg::EW-1:0] in_r01,
  input  logic signed [rmq_pkg::EW-1:0] in_r02,
  input  logic signed [rmq_pkg::EW-1:0] in_r10,
  input  logic signed [rmq_pkg::EW-1:0] in_r11,
  input  logic signed [rmq_pkg::EW-1:0] in_r12,
  input  logic signed [rmq_pkg::EW-1:0] in_r20,
  input  logic signed [rmq_pkg::EW-1:0] in_r21,
  input  logic signed [rmq_pkg::EW-1:0] in_r22,
  output logic                          out_valid,
  output logic signed [rmq_pkg::EW-1:0] out_quat_w,
  output logic signed [rmq_pkg::EW-1:0] out_quat_x,
  output logic signed [rmq_pkg::EW-1:0] out_quat_y,
  output logic signed [rmq_pkg::EW-1:0] out_quat_z,
  output logic [1:0]                    out_branch_taken
);
  import rmq_pkg::*;

  fr_t fr;
  rt_t rt;
  dv_t dv;

  // nothing is taken while the pipeline is held in reset
  assign busy = ~rst_n;

  rmq_front u_front (
    .clk, .rst_n, .in_valid(start),
    .in_r00, .in_r01, .in_r02, .in_r10, .in_r11, .in_r12,
    .in_r20, .in_r21, .in_r22,
    .fr_o(fr)
  );

  rmq_root u_root (.clk, .rst_n, .fr_i(fr), .rt_o(rt));

  rmq_quot u_quot (.clk, .rst_n, .rt_i(rt), .dv_o(dv));

  rmq_back u_back (
    .clk, .rst_n, .dv_i(dv),
    .out_valid, .out_quat_w, .out_quat_x, .out_quat_y, .out_quat_z,
    .out_branch_taken
  );
endmodule

[design/rmq_checker.sv]
// rmq_checker: port-level checks of the quaternion unit, bound to the top
// depends on rmq_pkg and rotation_matrix_to_quaternion_unit
`timescale 1ns / 1ps
module rmq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic signed [rmq_pkg::EW-1:0] out_quat_w,
  input logic signed [rmq_pkg::EW-1:0] out_quat_x,
  input logic signed [rmq_pkg::EW-1:0] out_quat_y,
  input logic signed [rmq_pkg::EW-1:0] out_quat_z,
  input logic [1:0]                    out_branch_taken
);
  import rmq_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("accepted word produced no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without an accepted word");

  // the component taken from the root is never negative
  a_dom_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_branch_taken == BR_TRACE && !out_quat_w[EW-1]) ||
                  (out_branch_taken == BR_X && !out_quat_x[EW-1]) ||
                  (out_branch_taken == BR_Y && !out_quat_y[EW-1]) ||
                  (out_branch_taken == BR_Z && !out_quat_z[EW-1]))
    else $error("dominant component negative");
endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);
